// ----- hw/rtl/unused_vertex_compactor_defines.svh -----
// ----------------------------------------------------------------------------
// Unused vertex compactor assertion macros
// Shared concurrent assertion forms for the compactor's checker.
// ----------------------------------------------------------------------------
`ifndef UNUSED_VERTEX_COMPACTOR_DEFINES_SVH
`define UNUSED_VERTEX_COMPACTOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define UVC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define UVC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/uvc_pkg.sv -----
// ----------------------------------------------------------------------------
// Unused vertex compactor package
// Field widths, capacity defaults, command codes and result kind codes.
// ----------------------------------------------------------------------------
package uvc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_INDICES  = 4096;

  localparam int CMD_W     = 2;
  localparam int PAYLOAD_W = 64;
  localparam int POS_W     = 10;
  localparam int KIND_W    = 2;

  localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INDEX  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_KEEP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IDX  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

endpackage

// ----- hw/rtl/unused_vertex_compactor.sv -----
// ----------------------------------------------------------------------------
// Unused vertex compactor
// Stores vertex payloads and triangle indices, then drains the used vertices (all
// when no index was loaded) at compacted positions, then the indices rewritten through a remap.
// ----------------------------------------------------------------------------
//  channel | handshake             | fields
//  --------+-----------------------+----------------------------------------
//  cmd     | cmd_valid / cmd_ready | command, vertex_payload, vertex_index
//  res     | res_valid / res_ready | kind, payload_out, position_out, last
//
//  A rejected load passes through an error state that issues an error result;
//  other loads are simply stored. A drain tick scans vertices, each by a mark
//  memory read and then a test, up to the next kept vertex, which it outputs;
//  an index result passes through index read, remap read and output states,
//  after a final vertex-scan check on the tick that also ends the vertex scan.
//  Used marks are cleared as each vertex is loaded: no clearing pass, and
//  the block accepts a transaction as soon as reset is released.
//  A held result stalls the next transaction only when it must produce one.
// ----------------------------------------------------------------------------
module unused_vertex_compactor #(
  parameter int MaxVertices = uvc_pkg::MAX_VERTICES,
  parameter int MaxIndices  = uvc_pkg::MAX_INDICES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [uvc_pkg::CMD_W-1:0]     command,
  input  logic [uvc_pkg::PAYLOAD_W-1:0] vertex_payload,
  input  logic [uvc_pkg::POS_W-1:0]     vertex_index,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [uvc_pkg::KIND_W-1:0]    kind,
  output logic [uvc_pkg::PAYLOAD_W-1:0] payload_out,
  output logic [uvc_pkg::POS_W-1:0]     position_out,
  output logic                          last
);

  localparam int POS_W = uvc_pkg::POS_W;
  localparam int VA    = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int IA    = (MaxIndices > 1) ? $clog2(MaxIndices) : 1;
  localparam int VCW   = $clog2(MaxVertices + 1);
  localparam int ICW   = $clog2(MaxIndices + 1);
  localparam int DPW   = (VCW > ICW) ? VCW : ICW;
  localparam int CMPW  = (VCW > POS_W) ? VCW : POS_W;

  localparam logic [1:0] PH_LOAD    = 2'd0;
  localparam logic [1:0] PH_VERTS   = 2'd1;
  localparam logic [1:0] PH_INDICES = 2'd2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_VRD  = 3'd2;
  localparam logic [2:0] S_VCHK = 3'd3;
  localparam logic [2:0] S_IRD  = 3'd4;
  localparam logic [2:0] S_IREM = 3'd5;
  localparam logic [2:0] S_IOUT = 3'd6;

  logic [uvc_pkg::PAYLOAD_W-1:0] vert_mem [MaxVertices];
  logic [POS_W:0]                meta_mem [MaxVertices];
  logic [POS_W-1:0]              idx_mem  [MaxIndices];

  logic [uvc_pkg::PAYLOAD_W-1:0] vert_rd;
  logic [POS_W:0]                meta_rd;
  logic [POS_W-1:0]              idx_rd;

  logic [2:0]     state, state_next;
  logic [1:0]     phase, phase_next;
  logic [VCW-1:0] vcount, vcount_next;
  logic [ICW-1:0] icount, icount_next;
  logic [DPW-1:0] dp, dp_next;
  logic [VCW-1:0] kept, kept_next;

  logic                          cmd_accept, slot_free, finish;
  logic                          vtx_err, idx_err, keep_all, v_last, i_last;
  logic [DPW-1:0]                dp_inc;
  logic                          res_load;
  logic [uvc_pkg::KIND_W-1:0]    res_kind;
  logic [uvc_pkg::PAYLOAD_W-1:0] res_pay;
  logic [POS_W-1:0]              res_pos;
  logic                          res_last;
  logic                          vert_we, meta_we, idx_we, vert_re, meta_re, idx_re;
  logic [VA-1:0]                 meta_wa, meta_ra;
  logic [POS_W:0]                meta_wd;

  assign cmd_ready  = (state == S_IDLE);
  assign cmd_accept = cmd_valid && cmd_ready;
  assign slot_free  = !res_valid || res_ready;

  assign vtx_err  = (phase != PH_LOAD) || (vcount == VCW'(MaxVertices));
  assign idx_err  = (phase != PH_LOAD) || (icount == ICW'(MaxIndices)) ||
                    !(CMPW'(vertex_index) < CMPW'(vcount));
  assign keep_all = (icount == '0);
  assign dp_inc   = dp + DPW'(1);
  assign v_last   = keep_all && (dp_inc == DPW'(vcount));
  assign i_last   = (dp_inc == DPW'(icount));

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    vcount_next = vcount;
    icount_next = icount;
    dp_next     = dp;
    kept_next   = kept;
    finish      = 1'b0;
    res_load    = 1'b0;
    res_kind    = uvc_pkg::KIND_ERR;
    res_pay     = '0;
    res_pos     = '0;
    res_last    = 1'b0;
    vert_we     = 1'b0;
    meta_we     = 1'b0;
    idx_we      = 1'b0;
    vert_re     = 1'b0;
    meta_re     = 1'b0;
    idx_re      = 1'b0;
    meta_wa     = dp[VA-1:0];
    meta_wd     = '0;
    meta_ra     = dp[VA-1:0];
    unique case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          unique case (command)
            uvc_pkg::CMD_VERTEX: begin
              if (vtx_err) begin
                state_next = S_ERR;
              end else begin
                vert_we     = 1'b1;
                meta_we     = 1'b1;
                meta_wa     = vcount[VA-1:0];
                meta_wd     = '0;
                vcount_next = vcount + VCW'(1);
              end
            end
            uvc_pkg::CMD_INDEX: begin
              if (idx_err) begin
                state_next = S_ERR;
              end else begin
                idx_we      = 1'b1;
                meta_we     = 1'b1;
                meta_wa     = VA'(vertex_index);
                meta_wd     = {1'b1, POS_W'(0)};
                icount_next = icount + ICW'(1);
              end
            end
            uvc_pkg::CMD_DRAIN: begin
              if (phase == PH_LOAD) begin
                if (vcount == '0) begin
                  finish = 1'b1;
                end else begin
                  phase_next = PH_VERTS;
                  dp_next    = '0;
                  kept_next  = '0;
                  state_next = S_VRD;
                end
              end else if (phase == PH_VERTS) begin
                state_next = S_VRD;
              end else begin
                state_next = S_IRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ERR: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_VRD: begin
        if (dp >= DPW'(vcount)) begin
          phase_next = PH_INDICES;
          dp_next    = '0;
          state_next = S_IRD;
        end else begin
          vert_re    = 1'b1;
          meta_re    = 1'b1;
          state_next = S_VCHK;
        end
      end
      S_VCHK: begin
        if (!(keep_all || meta_rd[POS_W])) begin
          dp_next    = dp_inc;
          state_next = S_VRD;
        end else if (slot_free) begin
          res_load   = 1'b1;
          res_kind   = uvc_pkg::KIND_KEEP;
          res_pay    = vert_rd;
          res_pos    = POS_W'(kept);
          res_last   = v_last;
          meta_we    = 1'b1;
          meta_wd    = {1'b0, POS_W'(kept)};
          kept_next  = kept + VCW'(1);
          dp_next    = dp_inc;
          finish     = v_last;
          state_next = S_IDLE;
        end
      end
      S_IRD: begin
        if (dp >= DPW'(icount)) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          idx_re     = 1'b1;
          state_next = S_IREM;
        end
      end
      S_IREM: begin
        meta_re    = 1'b1;
        meta_ra    = VA'(idx_rd);
        state_next = S_IOUT;
      end
      S_IOUT: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_kind   = uvc_pkg::KIND_IDX;
          res_pos    = meta_rd[POS_W-1:0];
          res_last   = i_last;
          dp_next    = dp_inc;
          finish     = i_last;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      phase_next  = PH_LOAD;
      vcount_next = '0;
      icount_next = '0;
      dp_next     = '0;
      kept_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[vcount[VA-1:0]] <= vertex_payload;
    end
    if (vert_re) begin
      vert_rd <= vert_mem[dp[VA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    if (meta_re) begin
      meta_rd <= meta_mem[meta_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (idx_we) begin
      idx_mem[icount[IA-1:0]] <= vertex_index;
    end
    if (idx_re) begin
      idx_rd <= idx_mem[dp[IA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_LOAD;
      vcount    <= '0;
      icount    <= '0;
      dp        <= '0;
      kept      <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      vcount <= vcount_next;
      icount <= icount_next;
      dp     <= dp_next;
      kept   <= kept_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind         <= res_kind;
      payload_out  <= res_pay;
      position_out <= res_pos;
      last         <= res_last;
    end
  end

endmodule

// ----- hw/rtl/uvc_checker.sv -----
// ----------------------------------------------------------------------------
// Unused vertex compactor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "unused_vertex_compactor_defines.svh"

module uvc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [uvc_pkg::KIND_W-1:0]    kind,
  input logic [uvc_pkg::PAYLOAD_W-1:0] payload_out,
  input logic [uvc_pkg::POS_W-1:0]     position_out,
  input logic                          last
);

  `UVC_ASSERT(a_err_fields_zero, clk, rst, res_valid && kind == uvc_pkg::KIND_ERR |-> payload_out == '0 && position_out == '0 && !last, "rejected load result carries data")
  `UVC_ASSERT(a_idx_payload_zero, clk, rst, res_valid && kind == uvc_pkg::KIND_IDX |-> payload_out == '0, "index result carries a payload")
  `UVC_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(payload_out) && $stable(position_out) && $stable(last), "stalled result changed")
  `UVC_ASSERT_ALWAYS(a_no_res_after_rst, clk, $past(rst) |-> !res_valid, "result valid right after reset")

endmodule

bind unused_vertex_compactor uvc_checker u_uvc_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .kind         (kind),
  .payload_out  (payload_out),
  .position_out (position_out),
  .last         (last)
);
